/* hdl/s20_pkg.sv */
`timescale 1ns / 1ps

package s20_pkg;

  localparam int ROUND_COUNT   = 20;
  localparam int DOUBLE_ROUNDS = (ROUND_COUNT + 1) / 2;
  localparam int DR_W          = $clog2(DOUBLE_ROUNDS + 1);
  localparam int PHASES        = 8;
  localparam int PHASE_W       = $clog2(PHASES);

  localparam int POS_W = 7;
  localparam logic [POS_W-1:0] BLOCK_BYTES = 7'd64;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  // register index codes, taken from paddr[5:3]
  localparam logic [2:0] REG_KEY0  = 3'd0;
  localparam logic [2:0] REG_KEY1  = 3'd1;
  localparam logic [2:0] REG_KEY2  = 3'd2;
  localparam logic [2:0] REG_KEY3  = 3'd3;
  localparam logic [2:0] REG_MODE  = 3'd4;
  localparam logic [2:0] REG_NONCE = 3'd5;

  // "expand 32-byte k" and "expand 16-byte k", little-endian words
  localparam logic [31:0] SIGMA [4] = '{32'h61707865, 32'h3320646e,
                                        32'h79622d32, 32'h6b206574};
  localparam logic [31:0] TAU [4]   = '{32'h61707865, 32'h3120646e,
                                        32'h79622d36, 32'h6b206574};

  // quarter-round word quartets (a, b, c, d): column round, then row round
  localparam logic [3:0] QR_IDX [8][4] = '{
    '{4'd0,  4'd4,  4'd8,  4'd12},
    '{4'd5,  4'd9,  4'd13, 4'd1},
    '{4'd10, 4'd14, 4'd2,  4'd6},
    '{4'd15, 4'd3,  4'd7,  4'd11},
    '{4'd0,  4'd1,  4'd2,  4'd3},
    '{4'd5,  4'd6,  4'd7,  4'd4},
    '{4'd10, 4'd11, 4'd8,  4'd9},
    '{4'd15, 4'd12, 4'd13, 4'd14}
  };
  localparam logic [4:0] QR_ROT [4] = '{5'd7, 5'd9, 5'd13, 5'd18};

  typedef logic [15:0][31:0] words_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       final_out;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key0;
    logic [63:0] key1;
    logic [63:0] key2;
    logic [63:0] key3;
    logic        mode;
    logic [63:0] nonce;
  } cfg_t;

  typedef struct packed {
    logic   start;
    words_t init;
  } core_req_t;

  // one step of one quarter-round lane: t ^= rotl(x + y, r)
  function automatic words_t lane_op(words_t w, logic row, logic [1:0] lane,
                                     logic [1:0] step);
    logic [3:0]  t;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [4:0]  r;
    logic [31:0] s;
    t = QR_IDX[{row, lane}][step + 2'd1];
    x = QR_IDX[{row, lane}][step];
    y = QR_IDX[{row, lane}][step - 2'd1];
    r = QR_ROT[step];
    s = w[x] + w[y];
    w[t] = w[t] ^ ((s << r) | (s >> (6'd32 - {1'b0, r})));
    return w;
  endfunction

  function automatic words_t build_init(cfg_t c, logic [63:0] ctr);
    words_t      w;
    logic [63:0] hk0;
    logic [63:0] hk1;
    hk0 = c.mode ? c.key2 : c.key0;
    hk1 = c.mode ? c.key3 : c.key1;
    w[0]  = c.mode ? SIGMA[0] : TAU[0];
    w[1]  = c.key0[31:0];
    w[2]  = c.key0[63:32];
    w[3]  = c.key1[31:0];
    w[4]  = c.key1[63:32];
    w[5]  = c.mode ? SIGMA[1] : TAU[1];
    w[6]  = c.nonce[31:0];
    w[7]  = c.nonce[63:32];
    w[8]  = ctr[31:0];
    w[9]  = ctr[63:32];
    w[10] = c.mode ? SIGMA[2] : TAU[2];
    w[11] = hk0[31:0];
    w[12] = hk0[63:32];
    w[13] = hk1[31:0];
    w[14] = hk1[63:32];
    w[15] = c.mode ? SIGMA[3] : TAU[3];
    return w;
  endfunction

endpackage

/* hdl/s20_in_queue.sv */
`timescale 1ns / 1ps

module s20_in_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  s20_pkg::in_item_t in_item,
  output logic             q_valid,
  output s20_pkg::in_item_t q_item,
  input  logic             q_pop
);

  s20_pkg::in_item_t             mem_r [s20_pkg::Q_DEPTH];
  logic [s20_pkg::Q_PTR_W-1:0]   wr_ptr_r;
  logic [s20_pkg::Q_PTR_W-1:0]   rd_ptr_r;
  logic [s20_pkg::Q_CNT_W-1:0]   count_r;
  logic [s20_pkg::Q_PTR_W-1:0]   wr_ptr_nxt;
  logic [s20_pkg::Q_PTR_W-1:0]   rd_ptr_nxt;
  logic [s20_pkg::Q_CNT_W-1:0]   count_nxt;
  logic                          push;

  assign in_stall = (count_r == s20_pkg::Q_CNT_W'(s20_pkg::Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == s20_pkg::Q_PTR_W'(s20_pkg::Q_DEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == s20_pkg::Q_PTR_W'(s20_pkg::Q_DEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (q_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= s20_pkg::Q_CNT_W'(s20_pkg::Q_DEPTH))
    else $error("input queue holds more items than its depth");

endmodule

/* hdl/s20_core.sv */
`timescale 1ns / 1ps

module s20_core (
  input  logic               clk,
  input  logic               rst_n,
  input  s20_pkg::core_req_t req,
  output logic               done,
  output s20_pkg::words_t    words
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RUN  = 2'd1;
  localparam logic [1:0] C_ADD  = 2'd2;

  logic [1:0]                  state_r;
  logic [s20_pkg::PHASE_W-1:0] phase_r;
  logic [s20_pkg::DR_W-1:0]    dr_r;
  logic                        done_r;
  s20_pkg::words_t             w_r;
  s20_pkg::words_t             init_r;
  s20_pkg::words_t             cand [s20_pkg::PHASES];

  // phase p: column round for p < 4, row round above; step p % 4 of all lanes
  for (genvar p = 0; p < s20_pkg::PHASES; p++) begin : g_phase
    always_comb begin
      s20_pkg::words_t acc;
      acc = w_r;
      for (int l = 0; l < 4; l++) begin
        acc = s20_pkg::lane_op(acc, 1'(p / 4), 2'(l), 2'(p % 4));
      end
      cand[p] = acc;
    end
  end

  assign done  = done_r;
  assign words = w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      phase_r <= '0;
      dr_r    <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        C_IDLE: begin
          if (req.start) begin
            state_r <= C_RUN;
            phase_r <= '0;
            dr_r    <= '0;
          end
        end
        C_RUN: begin
          phase_r <= phase_r + 1'b1;
          if (phase_r == s20_pkg::PHASE_W'(s20_pkg::PHASES - 1)) begin
            dr_r <= dr_r + 1'b1;
            if (dr_r == s20_pkg::DR_W'(s20_pkg::DOUBLE_ROUNDS - 1)) begin
              state_r <= C_ADD;
            end
          end
        end
        C_ADD: begin
          state_r <= C_IDLE;
          done_r  <= 1'b1;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == C_IDLE && req.start) begin
      w_r    <= req.init;
      init_r <= req.init;
    end else if (state_r == C_RUN) begin
      w_r <= cand[phase_r];
    end else if (state_r == C_ADD) begin
      // feed-forward of the starting words
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= w_r[i] + init_r[i];
      end
    end
  end

endmodule

/* hdl/s20_back.sv */
`timescale 1ns / 1ps

module s20_back (
  input  logic                clk,
  input  logic                rst_n,
  input  s20_pkg::cfg_t       cfg,
  input  logic                restart,
  input  logic                q_valid,
  input  s20_pkg::in_item_t   q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output s20_pkg::out_item_t  out_item
);

  logic [s20_pkg::POS_W-1:0] pos_r;
  logic [s20_pkg::POS_W-1:0] pos_nxt;
  logic [63:0]               ctr_r;
  logic [63:0]               ctr_nxt;
  logic                      gen_r;
  logic                      gen_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  s20_pkg::out_item_t        out_item_r;
  s20_pkg::out_item_t        out_item_nxt;
  s20_pkg::core_req_t        core_req;
  logic                      core_done;
  s20_pkg::words_t           core_words;
  logic [31:0]               ks_word;
  logic [7:0]                ks_byte;

  s20_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (core_req),
    .done  (core_done),
    .words (core_words)
  );

  // the core's word register doubles as the keystream buffer
  assign ks_word = core_words[pos_r[5:2]];
  assign ks_byte = 8'(ks_word >> {pos_r[1:0], 3'b000});

  always_comb begin
    pos_nxt       = pos_r;
    ctr_nxt       = ctr_r;
    gen_nxt       = gen_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    q_pop         = 1'b0;
    core_req.start = 1'b0;
    core_req.init  = s20_pkg::build_init(cfg, ctr_r);
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (restart) begin
      pos_nxt = s20_pkg::BLOCK_BYTES;
      ctr_nxt = '0;
    end else if (core_done) begin
      gen_nxt = 1'b0;
      pos_nxt = '0;
    end else if (q_valid && !gen_r) begin
      if (pos_r[6]) begin
        // block used up: make the next one before taking the item
        core_req.start = 1'b1;
        gen_nxt        = 1'b1;
        ctr_nxt        = ctr_r + 64'd1;
      end else if (!out_valid_r || !out_stall) begin
        q_pop                  = 1'b1;
        pos_nxt                = pos_r + 1'b1;
        out_valid_nxt          = 1'b1;
        out_item_nxt.out_byte  = q_item.data_byte ^ ks_byte;
        out_item_nxt.final_out = q_item.final_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= s20_pkg::BLOCK_BYTES;
      ctr_r       <= '0;
      gen_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      ctr_r       <= ctr_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_pop_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !pos_r[6])
    else $error("item taken with no keystream left in the block");

  a_done_while_gen: assert property (@(posedge clk) disable iff (!rst_n)
    core_done |-> gen_r)
    else $error("core finished a block that was never started");

  a_no_pop_while_gen: assert property (@(posedge clk) disable iff (!rst_n)
    gen_r |-> !q_pop)
    else $error("item taken while the keystream block is being made");

endmodule

/* hdl/salsa20_stream_cipher.sv */
`timescale 1ns / 1ps

// Salsa20 byte stream cipher: each input item's data byte is XORed with the
// next keystream byte and returned with its final mark.
// Input channel in_valid / in_stall / in_item feeds a two-item queue; the
// result channel out_valid / out_stall / out_item has an output register, so
// a stalled result does not block the queue from filling.
// Key, key length mode and nonce are written over the APB port (64-bit
// registers at 8-byte steps); any write to a defined register restarts the
// stream at block counter zero. Write only while no item is in flight.
// Inside a block an accepted item goes into the queue, is then taken, XORed
// and held in the output register. When a block is used up, the next one is
// made on the next item: the core runs one quarter-round step on all four
// lanes per cycle, and the byte is served once the block is finished.
// One byte per cycle is served within a block while the output is not stalled.
// Reset: registers to zero with 32-byte key mode, no keystream held; the
// first item starts a block. A stalled receiver holds the result; the queue
// then fills and in_stall rises.
module salsa20_stream_cipher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  s20_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output s20_pkg::out_item_t            out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [s20_pkg::PADDR_W-1:0]   paddr,
  input  logic [s20_pkg::PDATA_W-1:0]   pwdata,
  output logic [s20_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  s20_pkg::cfg_t     cfg_r;
  logic              cfg_wr;
  logic              restart;
  logic [2:0]        cfg_idx;
  logic              q_valid;
  s20_pkg::in_item_t q_item;
  logic              q_pop;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[5:3];

  always_comb begin
    case (cfg_idx)
      s20_pkg::REG_KEY0:  restart = cfg_wr;
      s20_pkg::REG_KEY1:  restart = cfg_wr;
      s20_pkg::REG_KEY2:  restart = cfg_wr;
      s20_pkg::REG_KEY3:  restart = cfg_wr;
      s20_pkg::REG_MODE:  restart = cfg_wr;
      s20_pkg::REG_NONCE: restart = cfg_wr;
      default:            restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key0  <= '0;
      cfg_r.key1  <= '0;
      cfg_r.key2  <= '0;
      cfg_r.key3  <= '0;
      cfg_r.mode  <= 1'b1;
      cfg_r.nonce <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        s20_pkg::REG_KEY0:  cfg_r.key0  <= pwdata;
        s20_pkg::REG_KEY1:  cfg_r.key1  <= pwdata;
        s20_pkg::REG_KEY2:  cfg_r.key2  <= pwdata;
        s20_pkg::REG_KEY3:  cfg_r.key3  <= pwdata;
        s20_pkg::REG_MODE:  cfg_r.mode  <= pwdata[0];
        s20_pkg::REG_NONCE: cfg_r.nonce <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      s20_pkg::REG_KEY0:  prdata = cfg_r.key0;
      s20_pkg::REG_KEY1:  prdata = cfg_r.key1;
      s20_pkg::REG_KEY2:  prdata = cfg_r.key2;
      s20_pkg::REG_KEY3:  prdata = cfg_r.key3;
      s20_pkg::REG_MODE:  prdata = {63'd0, cfg_r.mode};
      s20_pkg::REG_NONCE: prdata = cfg_r.nonce;
      default:            prdata = '0;
    endcase
  end

  s20_in_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  s20_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .restart   (restart),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* tb/sv/keystream_checker.sv */
`timescale 1ns / 1ps

module keystream_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  s20_pkg::in_item_t           in_item,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  s20_pkg::out_item_t          out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [s20_pkg::PADDR_W-1:0] paddr,
  input  logic [s20_pkg::PDATA_W-1:0] pwdata,
  input  logic [s20_pkg::PDATA_W-1:0] prdata,
  input  logic                        pready,
  output int                          errors,
  output int                          pending
);

  typedef logic [15:0][31:0] state16_t;

  // "expand 32-byte k" / "expand 16-byte k" as little-endian words
  localparam logic [31:0] EXP32 [4] = '{32'h61707865, 32'h3320646e,
                                        32'h79622d32, 32'h6b206574};
  localparam logic [31:0] EXP16 [4] = '{32'h61707865, 32'h3120646e,
                                        32'h79622d36, 32'h6b206574};

  logic [63:0] key_reg [4];
  logic        wide_key;
  logic [63:0] nonce_reg;
  logic [63:0] blk_ctr;
  int unsigned pos;
  logic [511:0] ks;
  s20_pkg::out_item_t cipher_q [$];
  s20_pkg::out_item_t want;
  logic [2:0]  reg_idx;
  logic        mapped;
  logic [63:0] reg_val;
  int          fail_cnt;

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic state16_t quarter_round(state16_t w, int a, int b, int c, int d);
    w[b] = w[b] ^ rotl(w[a] + w[d], 7);
    w[c] = w[c] ^ rotl(w[b] + w[a], 9);
    w[d] = w[d] ^ rotl(w[c] + w[b], 13);
    w[a] = w[a] ^ rotl(w[d] + w[c], 18);
    return w;
  endfunction

  function automatic state16_t salsa_block(logic [63:0] k0, logic [63:0] k1,
                                           logic [63:0] k2, logic [63:0] k3,
                                           logic wide, logic [63:0] nonce,
                                           logic [63:0] ctr);
    state16_t    init;
    state16_t    w;
    logic [63:0] hi0;
    logic [63:0] hi1;
    int          r;
    int          i;
    // a 16-byte key is repeated into the upper key words
    hi0 = wide ? k2 : k0;
    hi1 = wide ? k3 : k1;
    init[0]  = wide ? EXP32[0] : EXP16[0];
    init[1]  = k0[31:0];
    init[2]  = k0[63:32];
    init[3]  = k1[31:0];
    init[4]  = k1[63:32];
    init[5]  = wide ? EXP32[1] : EXP16[1];
    init[6]  = nonce[31:0];
    init[7]  = nonce[63:32];
    init[8]  = ctr[31:0];
    init[9]  = ctr[63:32];
    init[10] = wide ? EXP32[2] : EXP16[2];
    init[11] = hi0[31:0];
    init[12] = hi0[63:32];
    init[13] = hi1[31:0];
    init[14] = hi1[63:32];
    init[15] = wide ? EXP32[3] : EXP16[3];
    w = init;
    for (r = 0; r < (s20_pkg::ROUND_COUNT + 1) / 2; r++) begin
      w = quarter_round(w, 0, 4, 8, 12);
      w = quarter_round(w, 5, 9, 13, 1);
      w = quarter_round(w, 10, 14, 2, 6);
      w = quarter_round(w, 15, 3, 7, 11);
      w = quarter_round(w, 0, 1, 2, 3);
      w = quarter_round(w, 5, 6, 7, 4);
      w = quarter_round(w, 10, 11, 8, 9);
      w = quarter_round(w, 15, 12, 13, 14);
    end
    for (i = 0; i < 16; i++) begin
      w[i] = w[i] + init[i];
    end
    return w;
  endfunction

  task automatic note_fail(string msg);
    if (fail_cnt < 10) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    fail_cnt++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      key_reg[0] = '0;
      key_reg[1] = '0;
      key_reg[2] = '0;
      key_reg[3] = '0;
      wide_key   = 1'b1;
      nonce_reg  = '0;
      blk_ctr    = '0;
      pos        = 64;
      cipher_q.delete();
      fail_cnt   = 0;
      errors  <= 0;
      pending <= 0;
    end else begin
      reg_idx = paddr[5:3];
      mapped  = 1'b1;
      if (psel && penable && pready && pwrite) begin
        case (reg_idx)
          s20_pkg::REG_KEY0:  key_reg[0] = pwdata;
          s20_pkg::REG_KEY1:  key_reg[1] = pwdata;
          s20_pkg::REG_KEY2:  key_reg[2] = pwdata;
          s20_pkg::REG_KEY3:  key_reg[3] = pwdata;
          s20_pkg::REG_MODE:  wide_key   = pwdata[0];
          s20_pkg::REG_NONCE: nonce_reg  = pwdata;
          default:            mapped     = 1'b0;
        endcase
        // a write to a defined register restarts the stream
        if (mapped) begin
          blk_ctr = '0;
          pos     = 64;
        end
      end else if (psel && penable && pready) begin
        case (reg_idx)
          s20_pkg::REG_KEY0:  reg_val = key_reg[0];
          s20_pkg::REG_KEY1:  reg_val = key_reg[1];
          s20_pkg::REG_KEY2:  reg_val = key_reg[2];
          s20_pkg::REG_KEY3:  reg_val = key_reg[3];
          s20_pkg::REG_MODE:  reg_val = {63'd0, wide_key};
          s20_pkg::REG_NONCE: reg_val = nonce_reg;
          default:            mapped  = 1'b0;
        endcase
        if (mapped && prdata !== reg_val) begin
          note_fail($sformatf("read of register %0d gave %016h, expected %016h",
                              reg_idx, prdata, reg_val));
        end
      end

      if (out_valid && !out_stall) begin
        if (cipher_q.size() == 0) begin
          note_fail($sformatf("result byte %02h final %b with no item pending",
                              out_item.out_byte, out_item.final_out));
        end else begin
          want = cipher_q.pop_front();
          if (out_item.out_byte !== want.out_byte ||
              out_item.final_out !== want.final_out) begin
            note_fail($sformatf("byte %02h final %b, expected byte %02h final %b",
                                out_item.out_byte, out_item.final_out,
                                want.out_byte, want.final_out));
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (pos >= 64) begin
          ks      = salsa_block(key_reg[0], key_reg[1], key_reg[2], key_reg[3],
                                wide_key, nonce_reg, blk_ctr);
          blk_ctr = blk_ctr + 64'd1;
          pos     = 0;
        end
        want.out_byte  = in_item.data_byte ^ ks[pos*8 +: 8];
        want.final_out = in_item.final_byte;
        cipher_q.push_back(want);
        pos++;
      end

      errors  <= fail_cnt;
      pending <= cipher_q.size();
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  // addresses past the last register
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam logic [2:0] CFG_REGS [6] = '{s20_pkg::REG_KEY0, s20_pkg::REG_KEY1,
                                          s20_pkg::REG_KEY2, s20_pkg::REG_KEY3,
                                          s20_pkg::REG_MODE, s20_pkg::REG_NONCE};
  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_CYCLES  = 300;

  logic                        clk      = 1'b0;
  logic                        rst_n    = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  s20_pkg::in_item_t           in_item  = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b1;
  s20_pkg::out_item_t          out_item;
  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [s20_pkg::PADDR_W-1:0] paddr   = '0;
  logic [s20_pkg::PDATA_W-1:0] pwdata  = '0;
  logic [s20_pkg::PDATA_W-1:0] prdata;
  logic                        pready;
  int                          errors;
  int                          pending;
  bit                          tx_gaps     = 1'b0;
  bit                          rx_gaps     = 1'b0;
  bit                          rx_hold_req = 1'b0;

  salsa20_stream_cipher uut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_item,
    .out_valid, .out_stall, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  keystream_checker checker_i (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_item,
    .out_valid, .out_stall, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .errors, .pending
  );

  always #6 clk = ~clk;

  initial begin : watchdog
    #3_000_000;
    $display("[salsa20_stream_cipher] ERROR");
    $finish;
  end

  initial begin : result_sink
    int wait_cycles;
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      wait_cycles = rx_gaps ? $urandom_range(0, 16) : 0;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_byte(logic [7:0] data, logic fin);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= {data, fin};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic apb_access(logic wr, logic [2:0] idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_back();
    foreach (CFG_REGS[i]) begin
      apb_access(1'b0, CFG_REGS[i], '0);
    end
  endtask

  task automatic write_all(logic [63:0] key_val, logic [63:0] mode_val);
    foreach (CFG_REGS[i]) begin
      apb_access(1'b1, CFG_REGS[i],
                 CFG_REGS[i] == s20_pkg::REG_MODE ? mode_val : key_val);
    end
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 64'd0;
      1:       return {64{1'b1}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic reconfigure();
    int choice;
    bit wrote;
    choice = $urandom_range(0, 5);
    if (choice == 0) begin
      return;
    end
    if (choice == 1) begin
      apb_access(1'b1, $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, pick_word());
      return;
    end
    wrote = 1'b0;
    while (!wrote) begin
      foreach (CFG_REGS[i]) begin
        if ($urandom_range(0, 1)) begin
          apb_access(1'b1, CFG_REGS[i], pick_word());
          wrote = 1'b1;
        end
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      read_back();
    end
  endtask

  initial begin : stimulus
    int sent;
    int phase_len;
    bit held;
    sent = 0;
    held = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero key and nonce, 32-byte key
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h5a, 1'b0);
    send_byte(8'ha5, 1'b1);
    drain();
    read_back();

    // writes past the last register leave the stream running
    apb_access(1'b1, REG_SPARE_A, {64{1'b1}});
    apb_access(1'b1, REG_SPARE_B, {64{1'b1}});
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    drain();

    // all-ones key and nonce; mode keeps bit 0 only, so this is a 16-byte key
    write_all({64{1'b1}}, 64'hffff_ffff_ffff_fffe);
    read_back();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    repeat (4) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    drain();

    apb_access(1'b1, s20_pkg::REG_MODE, 64'h3);
    repeat (4) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    drain();

    write_all(64'd0, 64'd0);
    read_back();
    repeat (4) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    drain();

    while (sent < RANDOM_ITEMS) begin
      reconfigure();
      tx_gaps = $urandom_range(0, 3) != 0;
      rx_gaps = $urandom_range(0, 3) != 0;
      phase_len = $urandom_range(0, 3) == 0 ? $urandom_range(65, 140)
                                            : $urandom_range(5, 50);
      // receiver holds off while the sender keeps pushing
      if (!held && sent >= 150) begin
        held        = 1'b1;
        tx_gaps     = 1'b0;
        rx_hold_req = 1'b1;
        phase_len   = 120;
      end
      repeat (phase_len) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      sent += phase_len;
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[salsa20_stream_cipher] OK");
    end else begin
      $display("[salsa20_stream_cipher] ERROR");
    end
    $finish;
  end

endmodule
